// File: src/bdlod_pkg.sv
// Package for the box distance detail-level selector.
// Holds widths, register indexes, reset values and the job record passed
// from the front end through the queue to the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdlod_pkg;

    localparam int MAX_DEPTH  = 16;
    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
    localparam int COORD_W    = 32;
    localparam int MAG_W      = COORD_W + 1;
    localparam int HALF_W     = 31;
    localparam int THR_W      = 31;
    localparam int TDEPTH_W   = 5;
    localparam int LEVEL_W    = 4;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int D2_W       = SQ_W + 2;
    localparam int T2_W       = 2 * THR_W;
    localparam int CMP_W      = D2_W + 2 * MAX_DEPTH;
    localparam int LV_W       = (DEPTH_W > LEVEL_W) ? DEPTH_W : LEVEL_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_TREE_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_THRESH  = 2'd2;

    localparam logic [TDEPTH_W-1:0] RST_TREE_DEPTH  = 5'd8;
    localparam logic [THR_W-1:0]    RST_GEOM_THRESH = 31'd163840;
    localparam logic [THR_W-1:0]    RST_TEX_THRESH  = 31'd50233600;

    localparam logic KIND_GEOMETRY = 1'b0;
    localparam logic KIND_TEXTURE  = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [MAG_W-1:0]   mag_x;
        logic [MAG_W-1:0]   mag_y;
        logic [MAG_W-1:0]   mag_z;
        logic [HALF_W-1:0]  half_x;
        logic [HALF_W-1:0]  half_y;
        logic [HALF_W-1:0]  half_z;
        logic [THR_W-1:0]   thr;
        logic [DEPTH_W-1:0] depth;
    } t_job;

endpackage

`default_nettype wire

// File: src/bdlod_if.sv
// Channel interfaces of the box distance detail-level selector.
// Query, result and register write channels. Depends on bdlod_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdlod_in_if import bdlod_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [HALF_W-1:0]         half_x;
    logic [HALF_W-1:0]         half_y;
    logic [HALF_W-1:0]         half_z;
    logic signed [COORD_W-1:0] view_x;
    logic signed [COORD_W-1:0] view_y;
    logic signed [COORD_W-1:0] view_z;

    modport source (output valid, kind, center_x, center_y, center_z, half_x, half_y,
                    half_z, view_x, view_y, view_z, input ready);
    modport sink (input valid, kind, center_x, center_y, center_z, half_x, half_y,
                  half_z, view_x, view_y, view_z, output ready);
endinterface

interface bdlod_out_if import bdlod_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               saturated;

    modport source (output valid, level, saturated, input ready);
    modport sink (input valid, level, saturated, output ready);
endinterface

interface bdlod_cfg_if import bdlod_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/bdlod_front.sv
// Front end: configuration registers, query intake, per-axis offset magnitude,
// threshold and depth selection. Depends on bdlod_pkg and bdlod_if.
`timescale 1ns / 1ps
`default_nettype none

module bdlod_front import bdlod_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bdlod_in_if.sink    i_in,
    bdlod_cfg_if.sink   i_cfg,
    input  wire         i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [TDEPTH_W-1:0] r_tree_depth;
    logic [THR_W-1:0]    r_geom_thresh;
    logic [THR_W-1:0]    r_tex_thresh;
    logic                r_valid;
    t_job                r_job;
    t_job                n_job;

    logic signed [MAG_W-1:0] d_vc_x, d_cv_x, d_vc_y, d_cv_y, d_vc_z, d_cv_z;
    logic [THR_W-1:0]        thr_sel;
    logic                    take;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_depth  <= RST_TREE_DEPTH;
            r_geom_thresh <= RST_GEOM_THRESH;
            r_tex_thresh  <= RST_TEX_THRESH;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TREE_DEPTH:  r_tree_depth  <= i_cfg.data[TDEPTH_W-1:0];
                REG_GEOM_THRESH: r_geom_thresh <= i_cfg.data[THR_W-1:0];
                REG_TEX_THRESH:  r_tex_thresh  <= i_cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_push     = r_valid && !i_q_full;
    assign i_in.ready = !r_valid || !i_q_full;
    assign take       = i_in.valid && i_in.ready;
    assign o_job      = r_job;

    always_comb begin
        d_vc_x = {i_in.view_x[COORD_W-1], i_in.view_x} - {i_in.center_x[COORD_W-1], i_in.center_x};
        d_cv_x = {i_in.center_x[COORD_W-1], i_in.center_x} - {i_in.view_x[COORD_W-1], i_in.view_x};
        d_vc_y = {i_in.view_y[COORD_W-1], i_in.view_y} - {i_in.center_y[COORD_W-1], i_in.center_y};
        d_cv_y = {i_in.center_y[COORD_W-1], i_in.center_y} - {i_in.view_y[COORD_W-1], i_in.view_y};
        d_vc_z = {i_in.view_z[COORD_W-1], i_in.view_z} - {i_in.center_z[COORD_W-1], i_in.center_z};
        d_cv_z = {i_in.center_z[COORD_W-1], i_in.center_z} - {i_in.view_z[COORD_W-1], i_in.view_z};

        thr_sel = (i_in.kind == KIND_TEXTURE) ? r_tex_thresh : r_geom_thresh;

        n_job.mag_x  = d_vc_x[MAG_W-1] ? d_cv_x : d_vc_x;
        n_job.mag_y  = d_vc_y[MAG_W-1] ? d_cv_y : d_vc_y;
        n_job.mag_z  = d_vc_z[MAG_W-1] ? d_cv_z : d_vc_z;
        n_job.half_x = i_in.half_x;
        n_job.half_y = i_in.half_y;
        n_job.half_z = i_in.half_z;
        n_job.thr    = (thr_sel == '0) ? THR_W'(1) : thr_sel;
        if ({1'b0, r_tree_depth} > (TDEPTH_W + 1)'(MAX_DEPTH)) begin
            n_job.depth = DEPTH_W'(MAX_DEPTH);
        end else begin
            n_job.depth = DEPTH_W'(r_tree_depth);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

// File: src/bdlod_fifo.sv
// Short job queue between the front end and the back end.
// Depends on bdlod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdlod_fifo import bdlod_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  wire   i_pop,
    output t_job  o_job,
    output logic  o_empty
);

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: src/bdlod_back.sv
// Back end: gap, squares, squared distance, threshold ladder compare and
// level encoding in a stalling pipeline. Depends on bdlod_pkg and bdlod_if.
`timescale 1ns / 1ps
`default_nettype none

module bdlod_back import bdlod_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_q_empty,
    input  t_job         i_job,
    output logic         o_pop,
    bdlod_out_if.source  o_out
);

    logic en;

    logic                  r_v0, r_v1, r_v2, r_v3, r_vo;
    logic [COORD_W-1:0]    r_gx, r_gy, r_gz;
    logic [THR_W-1:0]      r_thr0;
    logic [DEPTH_W-1:0]    r_d0, r_d1, r_d2, r_d3;
    logic [SQ_W-1:0]       r_sx, r_sy, r_sz;
    logic [T2_W-1:0]       r_t2_1, r_t2_2;
    logic [D2_W-1:0]       r_dd2;
    logic [MAX_DEPTH-1:0]  r_ge;
    logic [LEVEL_W-1:0]    r_level;
    logic                  r_sat;

    logic [COORD_W-1:0]    n_gx, n_gy, n_gz;
    logic [MAX_DEPTH-1:0]  n_ge;
    logic [DEPTH_W-1:0]    k;
    logic [LV_W-1:0]       lv;
    logic [LEVEL_W-1:0]    n_level;
    logic                  n_sat;

    function automatic logic [COORD_W-1:0] gap(input logic [MAG_W-1:0] mag,
                                               input logic [HALF_W-1:0] half);
        logic [MAG_W:0] diff;
        diff = {1'b0, mag} - (MAG_W + 1)'(half);
        return diff[MAG_W] ? '0 : diff[COORD_W-1:0];
    endfunction

    assign en    = !r_vo || o_out.ready;
    assign o_pop = en && !i_q_empty;

    always_comb begin
        n_gx = gap(i_job.mag_x, i_job.half_x);
        n_gy = gap(i_job.mag_y, i_job.half_y);
        n_gz = gap(i_job.mag_z, i_job.half_z);
    end

    always_comb begin
        for (int j = 1; j <= MAX_DEPTH; j++) begin
            n_ge[j-1] = (DEPTH_W'(j) <= r_d2) &&
                        (CMP_W'(r_dd2) >= (CMP_W'(r_t2_2) << (2 * j)));
        end
    end

    always_comb begin
        k  = DEPTH_W'($countones(r_ge));
        lv = LV_W'(r_d3) - LV_W'(k) - LV_W'(1);
        if (k >= r_d3) begin
            n_level = '0;
            n_sat   = 1'b1;
        end else begin
            n_level = (lv > LV_W'(15)) ? LEVEL_W'(15) : lv[LEVEL_W-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v0 <= o_pop;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gx    <= n_gx;
            r_gy    <= n_gy;
            r_gz    <= n_gz;
            r_thr0  <= i_job.thr;
            r_d0    <= i_job.depth;
            r_sx    <= r_gx * r_gx;
            r_sy    <= r_gy * r_gy;
            r_sz    <= r_gz * r_gz;
            r_t2_1  <= r_thr0 * r_thr0;
            r_d1    <= r_d0;
            r_dd2   <= D2_W'(r_sx) + D2_W'(r_sy) + D2_W'(r_sz);
            r_t2_2  <= r_t2_1;
            r_d2    <= r_d1;
            r_ge    <= n_ge;
            r_d3    <= r_d2;
            r_level <= n_level;
            r_sat   <= n_sat;
        end
    end

    assign o_out.valid     = r_vo;
    assign o_out.level     = r_level;
    assign o_out.saturated = r_sat;

endmodule

`default_nettype wire

// File: src/box_distance_lod_select_core.sv
// Top level of the box distance detail-level selector.
// Depends on bdlod_pkg, bdlod_if, bdlod_front, bdlod_fifo and bdlod_back.
//
// Each query beat on i_in carries a box (center and half extents), a viewpoint
// and a kind bit that selects the geometry or texture threshold. Exactly one
// result beat per query leaves on o_out, in query order, with the detail level
// and a flag that is set when the level was clamped at zero.
// Register writes on i_cfg are taken in any cycle; they must only be issued
// while no query is in flight.
// A query beat passes the front register, the four-entry job queue and five
// back-end pipeline registers on its way to the result beat. One query is
// accepted per cycle when nothing stalls, since every stage then passes one
// beat per cycle.
// When the receiver stalls, the back end holds its result and freezes, the
// queue fills, and i_in.ready falls once the front register cannot drain.
// Reset loads the register reset values and empties all stages and the queue.
`timescale 1ns / 1ps
`default_nettype none

module box_distance_lod_select_core import bdlod_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    bdlod_in_if.sink     i_in,
    bdlod_cfg_if.sink    i_cfg,
    bdlod_out_if.source  o_out
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_job job_in;
    t_job job_out;

    bdlod_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (job_in)
    );

    bdlod_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (q_empty)
    );

    bdlod_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (job_out),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// File: src/bdlod_checker.sv
// Port-level checker for the box distance detail-level selector, with the bind
// that attaches it to the top level. Depends on bdlod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdlod_checker import bdlod_pkg::*; (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               i_in_ready,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire [LEVEL_W-1:0] i_level,
    input wire               i_saturated
);

    logic [4:0] r_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_beat && !out_beat) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_beat && !in_beat) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_level) &&
        $stable(i_saturated))
        else $error("result changed while stalled");

    a_sat_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> i_level == '0)
        else $error("saturated result with nonzero level");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != '0)
        else $error("result beat without a pending query");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == '0 |-> i_in_ready)
        else $error("query port blocked while empty");

endmodule

bind box_distance_lod_select_core bdlod_checker u_bdlod_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_level     (o_out.level),
    .i_saturated (o_out.saturated)
);

`default_nettype wire
